// File: rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CLOSED  = 3'd5
  } phase_t;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;

  // header byte counts; the 64-bit length uses 8, which wraps to 0 in 3 bits
  localparam logic [2:0] EXT16_BYTES    = 3'd2;
  localparam logic [2:0] EXT64_BYTES    = 3'd0;
  localparam logic [2:0] MASK_KEY_BYTES = 3'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       data_valid;
    logic       binary_msg;
    logic       end_of_message;
    logic       closed_event;
  } result_t;

endpackage

// File: rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header/payload state machine; one word per cycle while fire is high;
// result is produced combinationally for the output buffer to register.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       rx_byte,
  input  logic             link_down,
  output logic             res_wr,
  output wsd_pkg::result_t res
);

  wsd_pkg::phase_t phase, phase_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        mask_present, mask_present_next;
  logic [2:0]  header_byte_count, header_byte_count_next;
  logic [63:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_position, mask_position_next;

  // shared decode
  logic        active;
  logic        is_data, is_bin, is_close;
  logic [2:0]  cnt_dec;
  logic [63:0] ext_len;
  logic [63:0] rem_dec;
  logic        pay_eom;
  logic        len_done;
  logic [63:0] len_val;
  logic        start;
  logic [63:0] start_len;
  logic        start_empty;
  logic [7:0]  key_byte;

  always_comb begin
    active   = fire && !link_down;
    is_bin   = frame_opcode == wsd_pkg::OP_BINARY;
    is_data  = (frame_opcode == wsd_pkg::OP_TEXT) || is_bin;
    is_close = frame_opcode == wsd_pkg::OP_CLOSE;
    cnt_dec  = header_byte_count - 3'd1;
    ext_len  = {bytes_remaining[55:0], rx_byte};
    rem_dec  = bytes_remaining - 64'd1;
    pay_eom  = rem_dec == 64'd0;
    len_done = 1'b0;
    len_val  = 64'd0;
    start    = 1'b0;
    start_len = bytes_remaining;
    case (phase)
      wsd_pkg::PH_HDR1: begin
        if ((rx_byte[6:0] != wsd_pkg::LEN_CODE16) &&
            (rx_byte[6:0] != wsd_pkg::LEN_CODE64)) begin
          len_done = active;
          len_val  = {57'd0, rx_byte[6:0]};
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        len_done = active && (cnt_dec == 3'd0);
        len_val  = ext_len;
      end
      wsd_pkg::PH_MASK: begin
        start     = active && (cnt_dec == 3'd0);
        start_len = bytes_remaining;
      end
      default: begin
      end
    endcase
    if (len_done && !mask_present_next) begin
      start     = 1'b1;
      start_len = len_val;
    end
    start_empty = start && (start_len == 64'd0);
    case (mask_position)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
    if (!mask_present) key_byte = 8'd0;
  end

  // next state
  always_comb begin
    phase_next             = phase;
    frame_opcode_next      = frame_opcode;
    mask_present_next      = mask_present;
    header_byte_count_next = header_byte_count;
    bytes_remaining_next   = bytes_remaining;
    mask_key_next          = mask_key;
    mask_position_next     = mask_position;
    if (fire && link_down && (phase <= wsd_pkg::PH_PAYLOAD)) begin
      phase_next = wsd_pkg::PH_CLOSED;
    end else if (active) begin
      case (phase)
        wsd_pkg::PH_HDR0: begin
          frame_opcode_next = rx_byte[3:0];
          phase_next        = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          mask_present_next = rx_byte[7];
          mask_key_next     = 32'd0;
          if (rx_byte[6:0] == wsd_pkg::LEN_CODE16) begin
            bytes_remaining_next   = 64'd0;
            header_byte_count_next = wsd_pkg::EXT16_BYTES;
            phase_next             = wsd_pkg::PH_EXTLEN;
          end else if (rx_byte[6:0] == wsd_pkg::LEN_CODE64) begin
            bytes_remaining_next   = 64'd0;
            header_byte_count_next = wsd_pkg::EXT64_BYTES;
            phase_next             = wsd_pkg::PH_EXTLEN;
          end else begin
            bytes_remaining_next = len_val;
          end
        end
        wsd_pkg::PH_EXTLEN: begin
          bytes_remaining_next   = ext_len;
          header_byte_count_next = cnt_dec;
        end
        wsd_pkg::PH_MASK: begin
          mask_key_next          = {mask_key[23:0], rx_byte};
          header_byte_count_next = cnt_dec;
        end
        wsd_pkg::PH_PAYLOAD: begin
          mask_position_next   = mask_position + 2'd1;
          bytes_remaining_next = rem_dec;
          if (pay_eom) begin
            phase_next = is_close ? wsd_pkg::PH_CLOSED : wsd_pkg::PH_HDR0;
          end
        end
        default: begin
        end
      endcase
      if (len_done && mask_present_next) begin
        header_byte_count_next = wsd_pkg::MASK_KEY_BYTES;
        phase_next             = wsd_pkg::PH_MASK;
      end
      if (start) begin
        mask_position_next = 2'd0;
        if (start_len != 64'd0) begin
          phase_next = wsd_pkg::PH_PAYLOAD;
        end else if (is_close) begin
          phase_next = wsd_pkg::PH_CLOSED;
        end else begin
          phase_next = wsd_pkg::PH_HDR0;
        end
      end
    end
  end

  // result
  always_comb begin
    res_wr = 1'b0;
    res    = '0;
    if (fire && (phase <= wsd_pkg::PH_PAYLOAD)) begin
      if (link_down) begin
        res_wr           = 1'b1;
        res.closed_event = 1'b1;
      end else if (start_empty) begin
        if (is_data) begin
          res_wr             = 1'b1;
          res.binary_msg     = is_bin;
          res.end_of_message = 1'b1;
        end else if (is_close) begin
          res_wr           = 1'b1;
          res.closed_event = 1'b1;
        end
      end else if (phase == wsd_pkg::PH_PAYLOAD) begin
        if (is_data) begin
          res_wr             = 1'b1;
          res.payload_byte   = rx_byte ^ key_byte;
          res.data_valid     = 1'b1;
          res.binary_msg     = is_bin;
          res.end_of_message = pay_eom;
        end else if (is_close && pay_eom) begin
          res_wr           = 1'b1;
          res.closed_event = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= wsd_pkg::PH_HDR0;
      frame_opcode      <= 4'd0;
      mask_present      <= 1'b0;
      header_byte_count <= 3'd0;
      bytes_remaining   <= 64'd0;
      mask_key          <= 32'd0;
      mask_position     <= 2'd0;
    end else begin
      phase             <= phase_next;
      frame_opcode      <= frame_opcode_next;
      mask_present      <= mask_present_next;
      header_byte_count <= header_byte_count_next;
      bytes_remaining   <= bytes_remaining_next;
      mask_key          <= mask_key_next;
      mask_position     <= mask_position_next;
    end
  end

endmodule

// File: rtl/wsd_outbuf.sv
// ----------------------------------------------------------------------------
// wsd_outbuf
// Output register with one skid entry; full holds off the input side.
// ----------------------------------------------------------------------------
module wsd_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  wsd_pkg::result_t wr_res,
  input  logic             out_stall,
  output logic             out_valid,
  output wsd_pkg::result_t out_res,
  output logic             full
);

  wsd_pkg::result_t skid_res;
  logic             skid_valid;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= wr;
      end
    end else if (wr) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (wr) begin
        out_res <= wr_res;
      end
    end else if (wr) begin
      skid_res <= wr_res;
    end
  end

endmodule

// File: rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// A word's result is registered in the output register, or in the skid entry
//   while the output stalls. Throughput: one word per cycle unless in_stall.
// The input stalls only while the skid entry holds a result behind a stalled
//   output. Reset (rst, synchronous) returns the parser to the first header
//   byte and empties the output register and skid entry.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       link_down,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic       data_valid,
  output logic       binary_msg,
  output logic       end_of_message,
  output logic       closed_event
);

  logic             fire;
  logic             res_wr;
  logic             buf_full;
  wsd_pkg::result_t res;
  wsd_pkg::result_t out_res;

  // stall only when the skid entry is taken; any word may then produce a result
  assign in_stall = buf_full;
  assign fire     = in_valid && !in_stall;

  // header parse, length countdown and unmasking
  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (rx_byte),
    .link_down (link_down),
    .res_wr    (res_wr),
    .res       (res)
  );

  // result register plus skid entry
  wsd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .wr        (res_wr),
    .wr_res    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (buf_full)
  );

  assign payload_byte   = out_res.payload_byte;
  assign data_valid     = out_res.data_valid;
  assign binary_msg     = out_res.binary_msg;
  assign end_of_message = out_res.end_of_message;
  assign closed_event   = out_res.closed_event;

endmodule
